FILE: rtl/ptrr_pkg.sv
package ptrr_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned SID_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OIDX_W   = 3;
  localparam int unsigned CNT_W    = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD        = 3'd0,
    REQ_ADD_PAUSED = 3'd1,
    REQ_RESTART    = 3'd2,
    REQ_PAUSE      = 3'd3,
    REQ_RESUME     = 3'd4,
    REQ_KILL       = 3'd5,
    REQ_SCHED      = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    SLOT_DEAD   = 2'd0,
    SLOT_START  = 2'd1,
    SLOT_PAUSED = 2'd2,
    SLOT_IDLE   = 2'd3
  } slot_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE = 2'b01,
    CTRL_EXEC = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/ptrr_if.sv
interface ptrr_req_if import ptrr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [SID_W-1:0] slot_id;

  modport source (output valid, output req_type, output slot_id, input ready);
  modport sink   (input valid, input req_type, input slot_id, output ready);
endinterface

interface ptrr_rsp_if import ptrr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OIDX_W-1:0]   slot_index;
  logic                ran;
  logic                from_start;
  logic [CNT_W-1:0]    live_count;
  logic [OIDX_W-1:0]   active_slot;

  modport source (
    output valid, output status, output slot_index, output ran, output from_start,
    output live_count, output active_slot, input ready
  );
  modport sink (
    input valid, input status, input slot_index, input ran, input from_start,
    input live_count, input active_slot, output ready
  );
endinterface

FILE: rtl/ptrr_ctrl.sv
module ptrr_ctrl import ptrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      CTRL_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        // wait until the result register is empty or being drained
        if (dp_status_i.out_free) begin
          cmd_o.execute = 1'b1;
          state_d       = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ptrr_datapath.sv
module ptrr_datapath import ptrr_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [SID_W-1:0]    slot_id_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [STATUS_W-1:0] rsp_status_o,
  output logic [OIDX_W-1:0]   rsp_slot_index_o,
  output logic                rsp_ran_o,
  output logic                rsp_from_start_o,
  output logic [CNT_W-1:0]    rsp_live_count_o,
  output logic [OIDX_W-1:0]   rsp_active_slot_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);

  // slot table and scheduler state
  slot_state_e        slot_q [SLOTS];
  slot_state_e        slot_d [SLOTS];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [OIDX_W-1:0]  last_q, last_d;

  // captured request
  req_e               req_q;
  logic [SID_W-1:0]   sid_q;

  // result register
  logic               out_valid_q;
  status_e            res_status_q, res_status_d;
  logic [OIDX_W-1:0]  res_idx_q, res_idx_d;
  logic               res_ran_q, res_ran_d;
  logic               res_fs_q, res_fs_d;
  logic [CNT_W-1:0]   res_cnt_q;
  logic [OIDX_W-1:0]  res_last_q;

  // lowest dead slot
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  logic [CMP_W-1:0]       sid_ext;
  logic [IDX_W-1:0]       sid_idx;
  logic [CMP_W-1:0]       scan_inc;
  logic [CMP_W-1:0]       cnt_ext;
  logic [IDX_W+OIDX_W-1:0] free_wide;
  logic [IDX_W+OIDX_W-1:0] scan_wide;
  slot_state_e            cur_state;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_q[i] == SLOT_DEAD) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign sid_ext   = CMP_W'(sid_q);
  assign sid_idx   = sid_ext[IDX_W-1:0];
  assign scan_inc  = CMP_W'(scan_q) + CMP_W'(1);
  assign cnt_ext   = CMP_W'(count_q);
  assign free_wide = {{OIDX_W{1'b0}}, free_idx};
  assign scan_wide = {{OIDX_W{1'b0}}, scan_q};
  assign cur_state = slot_q[scan_q];

  always_comb begin
    slot_d       = slot_q;
    count_d      = count_q;
    scan_d       = scan_q;
    last_d       = last_q;
    res_status_d = STATUS_OK;
    res_idx_d    = '0;
    res_ran_d    = 1'b0;
    res_fs_d     = 1'b0;
    unique case (req_q)
      REQ_ADD, REQ_ADD_PAUSED: begin
        if (free_found) begin
          slot_d[free_idx] = (req_q == REQ_ADD) ? SLOT_START : SLOT_PAUSED;
          if (count_q != CNT_MAX) begin
            count_d = count_q + CNT_W'(1);
          end
          res_idx_d = free_wide[OIDX_W-1:0];
        end else begin
          res_status_d = STATUS_FULL;
        end
      end
      REQ_RESTART, REQ_PAUSE, REQ_RESUME, REQ_KILL: begin
        if (sid_ext >= SLOTS_C) begin
          res_status_d = STATUS_RANGE;
        end else begin
          unique case (req_q)
            REQ_RESTART: slot_d[sid_idx] = SLOT_START;
            REQ_PAUSE:   slot_d[sid_idx] = SLOT_PAUSED;
            REQ_RESUME:  slot_d[sid_idx] = SLOT_IDLE;
            default: begin
              slot_d[sid_idx] = SLOT_DEAD;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
            end
          endcase
        end
      end
      REQ_SCHED: begin
        res_idx_d = scan_wide[OIDX_W-1:0];
        if (cur_state == SLOT_IDLE || cur_state == SLOT_START) begin
          res_ran_d      = 1'b1;
          res_fs_d       = (cur_state == SLOT_START);
          last_d         = scan_wide[OIDX_W-1:0];
          slot_d[scan_q] = SLOT_IDLE;
        end
        // pointer wraps at the live count as well as at the table end
        if (scan_inc >= cnt_ext || scan_inc >= SLOTS_C) begin
          scan_d = '0;
        end else begin
          scan_d = scan_inc[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= SLOT_DEAD;
      end
      count_q     <= '0;
      scan_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        slot_q  <= slot_d;
        count_q <= count_d;
        scan_q  <= scan_d;
        last_q  <= last_d;
      end
      if (cmd_i.execute) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      sid_q <= slot_id_i;
    end
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_ran_q    <= res_ran_d;
      res_fs_q     <= res_fs_d;
      res_cnt_q    <= count_d;
      res_last_q   <= last_d;
    end
  end

  assign status_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = res_status_q;
  assign rsp_slot_index_o  = res_idx_q;
  assign rsp_ran_o         = res_ran_q;
  assign rsp_from_start_o  = res_fs_q;
  assign rsp_live_count_o  = res_cnt_q;
  assign rsp_active_slot_o = res_last_q;

endmodule

FILE: rtl/process_table_round_robin_top.sv
// round-robin task slot table
// req_i carries one request per transfer: req_type (add, add paused, restart,
// pause, resume, kill, schedule step) and slot_id for the slot commands.
// rsp_o returns exactly one result per request, in request order: status,
// allocated or examined slot, grant flags, live count and last granted slot.
// a request transfer is captured, then executed into the result register,
// which raises the result valid; the controller's capture/execute sequence
// lets a new request be accepted only after the previous one has executed;
// the free-slot search and table update finish in the execute cycle.
// the result register lets a new request be taken while a result still waits.
// if the receiver stalls, the next request is held in execute until the
// result register drains; no request is accepted beyond that one.
// reset clears all slots to dead, the live count, the scan pointer and the
// last granted slot, and empties the result register.
module process_table_round_robin_top import ptrr_pkg::*; #(
  parameter int unsigned SLOTS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptrr_req_if.sink  req_i,
  ptrr_rsp_if.source rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  ptrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  ptrr_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .req_type_i        (req_i.req_type),
    .slot_id_i         (req_i.slot_id),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_slot_index_o  (rsp_o.slot_index),
    .rsp_ran_o         (rsp_o.ran),
    .rsp_from_start_o  (rsp_o.from_start),
    .rsp_live_count_o  (rsp_o.live_count),
    .rsp_active_slot_o (rsp_o.active_slot)
  );

endmodule
